// ===== rtl/core/tdg_pkg.sv =====
// Package for the tract direction gate: component widths, payload structs,
// the internal queue entry and the configuration register indexes.
// Used by every module under rtl/core.
package tdg_pkg;

  // Component format: two's complement, two integer bits (Q1.14 at 16 bits).
  localparam int COMP_WIDTH = 16;
  localparam int FRAC       = COMP_WIDTH - 2;
  // Squared magnitude and squared length of the eigenvector.
  localparam int SQ_W       = 2 * COMP_WIDTH - 1;
  localparam int LEN_W      = 2 * COMP_WIDTH + 1;
  // Accumulators of the square-root search; holds mag^2 scaled by 2^(2*FRAC+2).
  localparam int ACC_W      = 4 * COMP_WIDTH;
  // Dot product width (three Q2.28-style products).
  localparam int DOT_W      = 2 * COMP_WIDTH + 2;
  // Shift that brings a Q1.15 cosine to the dot product scale.
  localparam int COS_SHIFT  = 2 * FRAC - 15;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;

  typedef enum logic [0:0] {
    CFG_MIN_ANISOTROPY = 1'b0,
    CFG_MIN_COSINE     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    comp_t       eig_x;
    comp_t       eig_y;
    comp_t       eig_z;
    logic [15:0] anisotropy;
    comp_t       prev_x;
    comp_t       prev_y;
    comp_t       prev_z;
  } in_item_t;

  typedef struct packed {
    comp_t dir_x;
    comp_t dir_y;
    comp_t dir_z;
    logic  found;
    logic  flipped;
  } out_item_t;

  // Per-item facts carried alongside the normalizer.
  typedef struct packed {
    logic                         ok;    // anisotropy passes and vector nonzero
    logic [2:0]                   neg;   // eigenvector component signs
    logic [2:0][COMP_WIDTH-1:0]   prev;  // previous direction
  } side_t;

  // Queue entry between the classifier and the normalizer.
  typedef struct packed {
    side_t                  side;
    logic [2:0][SQ_W-1:0]   mag2;
    logic [LEN_W-1:0]       len2;
  } q_item_t;

endpackage

// ===== rtl/core/tract_direction_gate.sv =====
// Top level of the tract direction gate: configuration registers, the
// classifying front end, the queue and the normalizing back end.
// Depends on tdg_pkg, tdg_front, tdg_queue and tdg_back.
//
// One item is taken per clock cycle and one result leaves per cycle once the
// pipeline is full, while the output does not stall. On the way, the front
// register takes the item and its squares at acceptance, then the item enters
// the queue, passes one search stage per result bit of the normalizer
// (FRAC + 1), then rounding, dot product and output. The normalizer's
// bit-per-stage square-root search sets the depth of that pipeline. A stall
// on the output holds the back end; the queue and front register keep taking
// up to three more items before the input stalls.
module tract_direction_gate
  import tdg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] min_anisotropy_r;
  logic [15:0] min_cosine_r;
  logic        push, q_ready, pop, q_valid;
  q_item_t     push_item, q_item;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_anisotropy_r <= 16'd6554;
      min_cosine_r     <= 16'd26214;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_ANISOTROPY: min_anisotropy_r <= cfg_data;
        CFG_MIN_COSINE:     min_cosine_r     <= cfg_data;
        default:            ;
      endcase
    end
  end

  tdg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .min_anisotropy (min_anisotropy_r),
    .push           (push),
    .q_ready        (q_ready),
    .push_item      (push_item)
  );

  tdg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  tdg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .min_cosine (min_cosine_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // A result without a direction carries no flip and a zero vector.
  a_none_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |->
      (!out_data.flipped && out_data.dir_x == '0 && out_data.dir_y == '0
       && out_data.dir_z == '0))
    else $error("result without direction is not zero");

  // A chosen direction is a normalized vector and never all zero.
  a_found_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |->
      (out_data.dir_x != '0 || out_data.dir_y != '0 || out_data.dir_z != '0))
    else $error("chosen direction is the zero vector");

  // Nothing leaves the block right after reset.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== rtl/core/tdg_front.sv =====
// Front end of the tract direction gate: accepts items, squares the
// eigenvector components and classifies each item for the back end.
// Depends on tdg_pkg.
module tdg_front
  import tdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  input  logic [15:0] min_anisotropy,
  output logic        push,
  input  logic        q_ready,
  output q_item_t     push_item
);

  logic                          f_valid_r;
  logic                          f_pass_r;
  logic [2:0]                    f_neg_r;
  logic [2:0][COMP_WIDTH-1:0]    f_prev_r;
  logic [2:0][SQ_W-1:0]          f_mag2_r;
  logic                          load;
  logic signed [2*COMP_WIDTH-1:0] sq_x, sq_y, sq_z;
  logic [LEN_W-1:0]              len2;

  // The stage holds while its item cannot enter the queue.
  assign in_stall = f_valid_r && !q_ready;
  assign load     = !in_stall;

  // Component squares, registered at acceptance.
  assign sq_x = in_data.eig_x * in_data.eig_x;
  assign sq_y = in_data.eig_y * in_data.eig_y;
  assign sq_z = in_data.eig_z * in_data.eig_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (load) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_pass_r    <= in_data.anisotropy >= min_anisotropy;
      f_neg_r     <= {in_data.eig_z[COMP_WIDTH-1], in_data.eig_y[COMP_WIDTH-1],
                      in_data.eig_x[COMP_WIDTH-1]};
      f_prev_r[0] <= in_data.prev_x;
      f_prev_r[1] <= in_data.prev_y;
      f_prev_r[2] <= in_data.prev_z;
      f_mag2_r[0] <= sq_x[SQ_W-1:0];
      f_mag2_r[1] <= sq_y[SQ_W-1:0];
      f_mag2_r[2] <= sq_z[SQ_W-1:0];
    end
  end

  // Squared length and final classification on the way into the queue.
  assign len2 = LEN_W'(f_mag2_r[0]) + LEN_W'(f_mag2_r[1]) + LEN_W'(f_mag2_r[2]);

  assign push                = f_valid_r && q_ready;
  assign push_item.mag2      = f_mag2_r;
  assign push_item.len2      = len2;
  assign push_item.side.ok   = f_pass_r && (len2 != '0);
  assign push_item.side.neg  = f_neg_r;
  assign push_item.side.prev = f_prev_r;

endmodule

// ===== rtl/core/tdg_queue.sv =====
// Short register queue that decouples the classifier from the normalizer.
// Depends on tdg_pkg for the entry type.
module tdg_queue
  import tdg_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    q_ready,
  input  logic    pop,
  output logic    q_valid,
  output q_item_t q_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign q_ready = count_r != CNT_W'(DEPTH);
  assign q_valid = count_r != '0;
  assign q_item  = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/tdg_back.sv =====
// Back end of the tract direction gate: bit-per-stage normalizer, rounding,
// dot product with the previous direction and the final choice.
// Depends on tdg_pkg.
module tdg_back
  import tdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  q_item_t     q_item,
  output logic        pop,
  input  logic [15:0] min_cosine,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int NS = FRAC + 1;
  localparam logic [FRAC:0] UNIT = (FRAC + 1)'(1) << FRAC;

  logic advance;

  // Search stages: n is found one bit per stage, keeping acc = n^2*len2
  // and b = n*len2 so that each trial needs only shifts and adds.
  logic                        s_vld_r  [NS];
  side_t                       s_side_r [NS];
  logic [ACC_W-1:0]            s_len2_r [NS];
  logic [2:0][ACC_W-1:0]       s_t_r    [NS];
  logic [2:0][ACC_W-1:0]       s_acc_r  [NS];
  logic [2:0][ACC_W-1:0]       s_b_r    [NS];
  logic [2:0][FRAC:0]          s_n_r    [NS];

  // Rounding, dot product and output stages.
  logic                        r_vld_r;
  side_t                       r_side_r;
  logic [2:0][COMP_WIDTH-1:0]  r_u_r;
  logic                        d_vld_r;
  logic                        d_ok_r;
  logic                        d_start_r;
  logic [2:0][COMP_WIDTH-1:0]  d_u_r;
  logic [2:0][2*COMP_WIDTH-1:0] d_prod_r;
  logic                        o_vld_r;
  out_item_t                   o_data_r;

  // The whole pipeline moves while the output register can be refilled.
  assign advance   = !o_vld_r || !out_stall;
  assign pop       = advance && q_valid;
  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

  for (genvar j = 0; j < NS; j++) begin : g_srch
    localparam int K = FRAC - j;
    logic                  src_vld;
    side_t                 src_side;
    logic [ACC_W-1:0]      src_len2;
    logic [2:0][ACC_W-1:0] src_t, src_acc, src_b;
    logic [2:0][FRAC:0]    src_n;
    logic [2:0][ACC_W-1:0] acc_nxt, b_nxt;
    logic [2:0][FRAC:0]    n_nxt;

    // Stage input: the queue head for the first stage, else the stage before.
    if (j == 0) begin : g_first
      assign src_vld  = q_valid;
      assign src_side = q_item.side;
      assign src_len2 = ACC_W'(q_item.len2);
      assign src_acc  = '0;
      assign src_b    = '0;
      assign src_n    = '0;
      for (genvar l = 0; l < 3; l++) begin : g_t
        assign src_t[l] = ACC_W'(q_item.mag2[l]) << (2 * FRAC);
      end
    end else begin : g_next
      assign src_vld  = s_vld_r[j-1];
      assign src_side = s_side_r[j-1];
      assign src_len2 = s_len2_r[j-1];
      assign src_t    = s_t_r[j-1];
      assign src_acc  = s_acc_r[j-1];
      assign src_b    = s_b_r[j-1];
      assign src_n    = s_n_r[j-1];
    end

    // Trial of bit K in each lane: (n + 2^K)^2 * len2 against the target.
    always_comb begin
      logic [ACC_W-1:0] cand;
      for (int l = 0; l < 3; l++) begin
        cand = src_acc[l] + (src_b[l] << (K + 1)) + (src_len2 << (2 * K));
        if (cand <= src_t[l]) begin
          acc_nxt[l] = cand;
          b_nxt[l]   = src_b[l] + (src_len2 << K);
          n_nxt[l]   = src_n[l] | ((FRAC + 1)'(1) << K);
        end else begin
          acc_nxt[l] = src_acc[l];
          b_nxt[l]   = src_b[l];
          n_nxt[l]   = src_n[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_vld_r[j] <= 1'b0;
      end else if (advance) begin
        s_vld_r[j] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        s_side_r[j] <= src_side;
        s_len2_r[j] <= src_len2;
        s_t_r[j]    <= src_t;
        s_acc_r[j]  <= acc_nxt;
        s_b_r[j]    <= b_nxt;
        s_n_r[j]    <= n_nxt;
      end
    end
  end

  // Round to nearest: step up when (2n+1)^2 * len2 <= 4 * target.
  always_ff @(posedge clk) begin
    logic [ACC_W-1:0] quad;
    logic [FRAC:0]    mag;
    if (advance) begin
      r_side_r <= s_side_r[NS-1];
      for (int l = 0; l < 3; l++) begin
        quad = (s_acc_r[NS-1][l] << 2) + (s_b_r[NS-1][l] << 2) + s_len2_r[NS-1];
        mag  = s_n_r[NS-1][l];
        if (s_n_r[NS-1][l] < UNIT && quad <= (s_t_r[NS-1][l] << 2)) begin
          mag = s_n_r[NS-1][l] + 1'b1;
        end
        r_u_r[l] <= s_side_r[NS-1].neg[l] ? -COMP_WIDTH'(mag) : COMP_WIDTH'(mag);
      end
    end
  end

  // Products with the previous direction.
  always_ff @(posedge clk) begin
    if (advance) begin
      d_ok_r    <= r_side_r.ok;
      d_start_r <= r_side_r.prev == '0;
      d_u_r     <= r_u_r;
      for (int l = 0; l < 3; l++) begin
        d_prod_r[l] <= $signed(r_u_r[l]) * $signed(r_side_r.prev[l]);
      end
    end
  end

  // Choice of direction against the cosine threshold.
  always_ff @(posedge clk) begin
    logic signed [DOT_W-1:0] dot, thr;
    logic                    fnd, flp;
    if (advance) begin
      dot = DOT_W'($signed(d_prod_r[0])) + DOT_W'($signed(d_prod_r[1]))
          + DOT_W'($signed(d_prod_r[2]));
      thr = DOT_W'(min_cosine) << COS_SHIFT;
      fnd = 1'b0;
      flp = 1'b0;
      if (d_ok_r) begin
        if (d_start_r || dot > thr) begin
          fnd = 1'b1;
        end else if (-dot > thr) begin
          fnd = 1'b1;
          flp = 1'b1;
        end
      end
      o_data_r.found   <= fnd;
      o_data_r.flipped <= flp;
      o_data_r.dir_x   <= !fnd ? '0 : (flp ? -$signed(d_u_r[0]) : $signed(d_u_r[0]));
      o_data_r.dir_y   <= !fnd ? '0 : (flp ? -$signed(d_u_r[1]) : $signed(d_u_r[1]));
      o_data_r.dir_z   <= !fnd ? '0 : (flp ? -$signed(d_u_r[2]) : $signed(d_u_r[2]));
    end
  end

  // Stage valid bits after the search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (advance) begin
      r_vld_r <= s_vld_r[NS-1];
      d_vld_r <= r_vld_r;
      o_vld_r <= d_vld_r;
    end
  end

endmodule

// ===== verif/tdg_checker.sv =====
// Checker for the tract direction gate: watches the input, result and
// configuration channels, predicts each result and compares it.
// Depends on tdg_pkg.
module tdg_checker
  import tdg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  logic [15:0] cfg_data,
  output int        fail_count,
  output int        pending,
  output int        n_found,
  output int        n_flipped
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] fa_thresh;
  logic [15:0] cos_thresh;
  out_item_t   dir_queue[$];

  // Rounded normalized magnitude of one component, searched exactly.
  function automatic longint unsigned unit_mag(longint unsigned mag, longint unsigned len2);
    longint unsigned lo, hi, mid, n, m2;
    logic [127:0] lhs, rhs;
    m2 = mag * mag;
    lo = 0;
    hi = 64'd1 << FRAC;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 128'(mid * mid) * 128'(len2);
      rhs = 128'(m2) << (2 * FRAC);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    n = lo;
    if (n < (64'd1 << FRAC)) begin
      lhs = 128'((2 * n + 1) * (2 * n + 1)) * 128'(len2);
      rhs = 128'(m2) << (2 * FRAC + 2);
      if (lhs <= rhs) n++;
    end
    return n;
  endfunction

  // Next tracking direction for one voxel step.
  function automatic out_item_t next_direction(in_item_t it);
    out_item_t r;
    longint e[3], p[3], u[3];
    longint unsigned len2, m;
    longint dot, thr;
    e[0] = it.eig_x; e[1] = it.eig_y; e[2] = it.eig_z;
    p[0] = it.prev_x; p[1] = it.prev_y; p[2] = it.prev_z;
    r = '0;
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += e[i] * e[i];
    if (it.anisotropy >= fa_thresh && len2 != 0) begin
      dot = 0;
      thr = longint'(cos_thresh) <<< COS_SHIFT;
      for (int i = 0; i < 3; i++) begin
        m = unit_mag(e[i] < 0 ? -e[i] : e[i], len2);
        u[i] = e[i] < 0 ? -longint'(m) : longint'(m);
        dot += u[i] * p[i];
      end
      if (p[0] == 0 && p[1] == 0 && p[2] == 0) r.found = 1'b1;
      else if (dot > thr) r.found = 1'b1;
      else if (-dot > thr) begin
        r.found = 1'b1;
        r.flipped = 1'b1;
      end
      if (r.found) begin
        if (r.flipped) for (int i = 0; i < 3; i++) u[i] = -u[i];
        r.dir_x = comp_t'(u[0]);
        r.dir_y = comp_t'(u[1]);
        r.dir_z = comp_t'(u[2]);
      end
    end
    return r;
  endfunction

  assign pending = dir_queue.size();

  // Track register writes, predict on input transfers, compare on results.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fa_thresh  <= 16'd6554;
      cos_thresh <= 16'd26214;
      fail_count <= 0;
      n_found    <= 0;
      n_flipped  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MIN_ANISOTROPY) fa_thresh <= cfg_data;
        else cos_thresh <= cfg_data;
      end
      if (in_valid && !in_stall) dir_queue.push_back(next_direction(in_data));
      if (out_valid && !out_stall) begin
        if (dir_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = dir_queue.pop_front();
          if (want.found) n_found <= n_found + 1;
          if (want.flipped) n_flipped <= n_flipped + 1;
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: expected x=%0d y=%0d z=%0d f=%b n=%b, got x=%0d y=%0d z=%0d f=%b n=%b",
                       want.dir_x, want.dir_y, want.dir_z, want.found, want.flipped,
                       out_data.dir_x, out_data.dir_y, out_data.dir_z, out_data.found,
                       out_data.flipped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_tract_direction_gate.sv =====
// Testbench top for the tract direction gate: clock, reset, stimulus and
// verdict. Depends on tdg_pkg, tract_direction_gate and tdg_checker.
module tb_tract_direction_gate;
  import tdg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = FRAC + 6;
  localparam int MAX_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_MIN_ANISOTROPY;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending, n_found, n_flipped;
  int          cycles = 0;
  bit          quiet = 1'b0;
  int          out_gap = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tract_direction_gate DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tdg_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .n_found, .n_flipped
  );

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side stalls in random bursts.
  always @(posedge clk) begin
    if (quiet) out_stall <= 1'b0;
    else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Let the checker record the last transfer before watching the count.
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // One transfer on the input channel, with an optional idle burst first.
  task automatic send_step(in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic comp_t rand_unitish();
    case ($urandom_range(0, 3))
      0: return comp_t'($urandom_range(0, 32768) - 16384);
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return comp_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly well-formed steps: prev is a noisy copy of the (possibly negated) eigenvector.
  function automatic in_item_t rand_step();
    in_item_t it;
    int s;
    it.eig_x = comp_t'($urandom_range(0, 65535));
    it.eig_y = comp_t'($urandom_range(0, 65535));
    it.eig_z = comp_t'($urandom_range(0, 65535));
    if ($urandom_range(0, 7) == 0) begin
      it.eig_x = comp_t'($urandom_range(0, 8) - 4);
      it.eig_y = comp_t'($urandom_range(0, 8) - 4);
      it.eig_z = comp_t'($urandom_range(0, 8) - 4);
    end
    it.anisotropy = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(0, 32768));
    case ($urandom_range(0, 5))
      0: begin
        it.prev_x = 0; it.prev_y = 0; it.prev_z = 0;
      end
      1: begin
        it.prev_x = rand_unitish(); it.prev_y = rand_unitish(); it.prev_z = rand_unitish();
      end
      default: begin
        s = $urandom_range(0, 1) ? 1 : -1;
        it.prev_x = comp_t'(s * (it.eig_x >>> 1) + int'($urandom_range(0, 2000)) - 1000);
        it.prev_y = comp_t'(s * (it.eig_y >>> 1) + int'($urandom_range(0, 2000)) - 1000);
        it.prev_z = comp_t'(s * (it.eig_z >>> 1) + int'($urandom_range(0, 2000)) - 1000);
      end
    endcase
    return it;
  endfunction

  function automatic in_item_t mk(int ex, int ey, int ez, int fa, int px, int py, int pz);
    in_item_t it;
    it.eig_x = comp_t'(ex); it.eig_y = comp_t'(ey); it.eig_z = comp_t'(ez);
    it.anisotropy = 16'(fa);
    it.prev_x = comp_t'(px); it.prev_y = comp_t'(py); it.prev_z = comp_t'(pz);
    return it;
  endfunction

  initial begin
    logic [15:0] fa_set[4] = '{16'd0, 16'd6554, 16'd32768, 16'd65535};
    logic [15:0] cos_set[4] = '{16'd0, 16'd26214, 16'd32768, 16'd65535};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, start of fiber, low anisotropy, zero vector, flip, reject.
    send_step(mk(16384, 0, 0, 32768, 0, 0, 0));
    send_step(mk(-32768, -32768, -32768, 32768, 0, 0, 0));
    send_step(mk(32767, 32767, 32767, 65535, 9459, 9459, 9459));
    send_step(mk(1000, 2000, 3000, 6553, 0, 0, 0));
    send_step(mk(1000, 2000, 3000, 6554, 0, 0, 0));
    send_step(mk(0, 0, 0, 32768, 16384, 0, 0));
    send_step(mk(0, 0, 0, 0, 0, 0, 0));
    send_step(mk(16384, 0, 0, 20000, -16384, 0, 0));
    send_step(mk(0, 16384, 0, 20000, 16384, 0, 0));
    send_step(mk(1, 0, 0, 20000, 0, 16384, 0));
    send_step(mk(-1, 1, -1, 20000, -16384, 16384, -16384));
    send_step(mk(3000, 4000, 0, 20000, 16384, 16384, 16384));
    send_step(mk(-5, 7, 32767, 20000, -32768, 32767, -1));
    send_step(mk(16384, 16384, 0, 20000, 13107, 13107, 0));
    in_valid <= 1'b0;
    drain();

    // Register sweep with random steps; pauses for all results before each write.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_MIN_ANISOTROPY, ph < 4 ? fa_set[ph] : 16'($urandom_range(0, 32768)));
      write_reg(CFG_MIN_COSINE, ph < 4 ? cos_set[3 - ph] : 16'($urandom_range(0, 32768)));
      if (ph == 9) quiet = 1'b1;
      repeat (190) send_step(rand_step());
      in_valid <= 1'b0;
      drain();
    end

    $display("Covered %0d results with a direction, %0d of them flipped,", n_found,
             n_flipped);
    $display("across ten threshold settings including both extremes.");
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
